// File: hw/rtl/ati_pkg.sv
`timescale 1ns / 1ps
// ati_pkg: fixed widths, row codes and shared types of the affine inverse core
// no dependencies

package ati_pkg;

  // entry and intermediate widths (entries are fixed 32-bit two's complement)
  localparam int DATA_W = 32;
  localparam int PROD_W = 64;             // entry x entry
  localparam int COF_W  = 65;             // difference of two products
  localparam int PP_W   = 65;             // entry x 33-bit half of a cofactor
  localparam int TERM_W = 97;             // entry x cofactor
  localparam int SUM_W  = 99;             // sum of three terms
  localparam int MAG_W  = 98;             // magnitude of a sum of three terms
  localparam int QBITS  = 33;             // quotient bits kept by the divider
  localparam int DIV_LAT = QBITS + 2;     // range check, one stage per bit, sign and clamp
  localparam int LANES  = 4;              // three inverse entries plus translation

  // row codes
  localparam int ROW_W = 2;
  typedef logic [ROW_W-1:0] row_t;
  localparam row_t ROW0     = 2'd0;
  localparam row_t ROW1     = 2'd1;
  localparam row_t ROW_LAST = 2'd2;

  typedef logic signed [DATA_W-1:0] word_t;

endpackage

// File: hw/rtl/ati_if.sv
`timescale 1ns / 1ps
// ati_in_if / ati_out_if: valid-ready channels of the affine inverse core
// depends on ati_pkg

interface ati_in_if;
  import ati_pkg::*;
  logic  valid;
  logic  ready;
  word_t m00, m01, m02, m03;
  word_t m10, m11, m12, m13;
  word_t m20, m21, m22, m23;

  modport source (output valid, m00, m01, m02, m03, m10, m11, m12, m13,
                  m20, m21, m22, m23, input ready);
  modport sink   (input valid, m00, m01, m02, m03, m10, m11, m12, m13,
                  m20, m21, m22, m23, output ready);
endinterface

interface ati_out_if;
  import ati_pkg::*;
  logic  valid;
  logic  ready;
  row_t  row_index;
  word_t col0, col1, col2, col3;
  logic  singular;
  logic  saturated;
  logic  last_row;

  modport source (output valid, row_index, col0, col1, col2, col3, singular,
                  saturated, last_row, input ready);
  modport sink   (input valid, row_index, col0, col1, col2, col3, singular,
                  saturated, last_row, output ready);
endinterface

// File: hw/rtl/ati_div_pipe.sv
`timescale 1ns / 1ps
// ati_div_pipe: pipelined restoring divider, one quotient bit per stage,
// several numerators over one shared divisor, sign/saturate to 32 bits
// depends on ati_pkg

module ati_div_pipe
  import ati_pkg::*;
#(
  parameter int W = 133
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [LANES-1:0][W-1:0]       num,
  input  logic [W-1:0]                  den,
  input  logic [LANES-1:0]              neg,
  output logic [LANES-1:0][DATA_W-1:0]  res,
  output logic [LANES-1:0]              sat
);

  logic [LANES-1:0][W-1:0]     rem   [QBITS+1];
  logic [W-1:0]                dv    [QBITS+1];
  logic [LANES-1:0][QBITS-1:0] quo   [QBITS+1];
  logic [LANES-1:0]            ovf   [QBITS+1];
  logic [LANES-1:0]            sgn   [QBITS+1];

  // range check: quotient of 2^QBITS or more always saturates
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        rem[0][l] <= num[l];
        quo[0][l] <= '0;
        ovf[0][l] <= (num[l] >= (den << QBITS));
      end
      dv[0]  <= den;
      sgn[0] <= neg;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 1; s <= QBITS; s++) begin : g_stage
    localparam int B = QBITS - s;
    logic [W-1:0] shd;
    assign shd = dv[s-1] << B;

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          if (rem[s-1][l] >= shd) begin
            rem[s][l] <= rem[s-1][l] - shd;
            quo[s][l] <= quo[s-1][l] | (QBITS'(1) << B);
          end else begin
            rem[s][l] <= rem[s-1][l];
            quo[s][l] <= quo[s-1][l];
          end
        end
        dv[s]  <= dv[s-1];
        ovf[s] <= ovf[s-1];
        sgn[s] <= sgn[s-1];
      end
    end
  end

  // sign and clamp
  logic [LANES-1:0][QBITS-1:0]  lim;
  logic [LANES-1:0]             sat_c;
  logic [LANES-1:0][DATA_W-1:0] res_c;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lim[l]   = sgn[QBITS][l] ? (QBITS'(1) << (DATA_W-1))
                               : ((QBITS'(1) << (DATA_W-1)) - QBITS'(1));
      sat_c[l] = ovf[QBITS][l] || (quo[QBITS][l] > lim[l]);
      if (sat_c[l]) begin
        res_c[l] = lim[l][DATA_W-1:0];
      end else if (sgn[QBITS][l]) begin
        res_c[l] = DATA_W'(0) - quo[QBITS][l][DATA_W-1:0];
      end else begin
        res_c[l] = quo[QBITS][l][DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_c;
      sat <= sat_c;
    end
  end

endmodule

// File: hw/rtl/affine_transform_inverse_core.sv
`timescale 1ns / 1ps
// affine_transform_inverse_core: inverse of a 3x4 Q16.16 affine transform
// depends on ati_pkg, ati_if (ati_in_if, ati_out_if) and ati_div_pipe
//
// Usage:
//   in_ch carries one transform per word: twelve signed fixed-point entries
//   m00..m23 (column 3 is the translation). out_ch gives three words per
//   transform, rows 0, 1, 2 in order, last_row set on row 2. Each row holds
//   three inverse entries and the new translation, rounded to nearest (ties
//   away from zero) and clamped to 32 bits; saturated flags a clamp in that
//   row, singular a zero determinant (entries then zero).
// Throughput: one row per cycle while out_ch is not stalled; the input holding
//   register issues its three rows into the pipeline back to back.
// Pipeline: from acceptance of a transform until its first row is valid on
//   out_ch, the holding register loads at the accepting edge, then
//   7 arithmetic stages (products, cofactors, partial products, terms, sums,
//   magnitudes, dividends), 35 divider stages (range check, one per quotient
//   bit, sign and clamp) and the output register.
// Reset clears every valid bit; no words are in flight afterwards.
// A stall on out_ch freezes the whole pipeline; a new transform is still
//   taken while the holding register is free.

module affine_transform_inverse_core
  import ati_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  ati_in_if.sink    in_ch,
  ati_out_if.source out_ch
);

  localparam int NUM_A = MAG_W + 2 + FRAC_BITS;
  localparam int NUM_B = MAG_W + 1 + QBITS;
  localparam int NUM_W = (NUM_A > NUM_B ? NUM_A : NUM_B) + 1;

  logic adv;
  logic out_v;
  assign adv = !out_v || out_ch.ready;

  // holding register and row issue
  logic  hold_v;
  row_t  cnt;
  word_t hm [3][4];

  assign in_ch.ready = !hold_v || (adv && (cnt == ROW_LAST));

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      cnt    <= ROW0;
    end else if (in_ch.valid && in_ch.ready) begin
      hold_v <= 1'b1;
      cnt    <= ROW0;
    end else if (adv && hold_v) begin
      if (cnt == ROW_LAST) begin
        hold_v <= 1'b0;
      end else begin
        cnt <= cnt + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      hm[0][0] <= in_ch.m00; hm[0][1] <= in_ch.m01;
      hm[0][2] <= in_ch.m02; hm[0][3] <= in_ch.m03;
      hm[1][0] <= in_ch.m10; hm[1][1] <= in_ch.m11;
      hm[1][2] <= in_ch.m12; hm[1][3] <= in_ch.m13;
      hm[2][0] <= in_ch.m20; hm[2][1] <= in_ch.m21;
      hm[2][2] <= in_ch.m22; hm[2][3] <= in_ch.m23;
    end
  end

  // column pair of the adjugate row being issued
  word_t ca [3];
  word_t cb [3];

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      case (cnt)
        ROW0: begin
          ca[x] = hm[x][1];
          cb[x] = hm[x][2];
        end
        ROW1: begin
          ca[x] = hm[x][2];
          cb[x] = hm[x][0];
        end
        default: begin
          ca[x] = hm[x][0];
          cb[x] = hm[x][1];
        end
      endcase
    end
  end

  // stage 1: cofactor products for this row and for the determinant
  logic                     v1;
  row_t                     r1;
  logic signed [PROD_W-1:0] pa1 [3];
  logic signed [PROD_W-1:0] pb1 [3];
  logic signed [PROD_W-1:0] da1 [3];
  logic signed [PROD_W-1:0] db1 [3];
  word_t                    a01 [3];
  word_t                    b1  [3];

  for (genvar j = 0; j < 3; j++) begin : g_s1
    localparam int J1 = (j + 1) % 3;
    localparam int J2 = (j + 2) % 3;
    always_ff @(posedge clk) begin
      if (adv) begin
        pa1[j] <= ca[J1] * cb[J2];
        pb1[j] <= cb[J1] * ca[J2];
        da1[j] <= hm[1][J1] * hm[2][J2];
        db1[j] <= hm[1][J2] * hm[2][J1];
        a01[j] <= hm[0][j];
        b1[j]  <= hm[j][3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= hold_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1 <= cnt;
    end
  end

  // stage 2: cofactors
  logic                    v2;
  row_t                    r2;
  logic signed [COF_W-1:0] cr2 [3];
  logic signed [COF_W-1:0] cd2 [3];
  word_t                   a02 [3];
  word_t                   b2  [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      r2 <= r1;
      for (int j = 0; j < 3; j++) begin
        cr2[j] <= COF_W'(pa1[j]) - COF_W'(pb1[j]);
        cd2[j] <= COF_W'(da1[j]) - COF_W'(db1[j]);
        a02[j] <= a01[j];
        b2[j]  <= b1[j];
      end
    end
  end

  // stage 3: partial products on the two halves of each cofactor
  logic                   v3;
  row_t                   r3;
  logic signed [PP_W-1:0] dlo3 [3];
  logic signed [PP_W-1:0] dhi3 [3];
  logic signed [PP_W-1:0] tlo3 [3];
  logic signed [PP_W-1:0] thi3 [3];
  logic signed [COF_W-1:0] cr3 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      r3 <= r2;
      for (int j = 0; j < 3; j++) begin
        dlo3[j] <= a02[j] * $signed({1'b0, cd2[j][DATA_W-1:0]});
        dhi3[j] <= a02[j] * $signed(cd2[j][COF_W-1:DATA_W]);
        tlo3[j] <= b2[j] * $signed({1'b0, cr2[j][DATA_W-1:0]});
        thi3[j] <= b2[j] * $signed(cr2[j][COF_W-1:DATA_W]);
        cr3[j]  <= cr2[j];
      end
    end
  end

  // stage 4: full terms
  logic                     v4;
  row_t                     r4;
  logic signed [TERM_W-1:0] dt4 [3];
  logic signed [TERM_W-1:0] tt4 [3];
  logic signed [COF_W-1:0]  cr4 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      r4 <= r3;
      for (int j = 0; j < 3; j++) begin
        dt4[j] <= $signed({dhi3[j], {DATA_W{1'b0}}})
                  + $signed({{DATA_W{dlo3[j][PP_W-1]}}, dlo3[j]});
        tt4[j] <= $signed({thi3[j], {DATA_W{1'b0}}})
                  + $signed({{DATA_W{tlo3[j][PP_W-1]}}, tlo3[j]});
        cr4[j] <= cr3[j];
      end
    end
  end

  // stage 5: determinant and translation dot product
  logic                    v5;
  row_t                    r5;
  logic signed [SUM_W-1:0] det5;
  logic signed [SUM_W-1:0] tr5;
  logic signed [COF_W-1:0] cr5 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      r5   <= r4;
      det5 <= SUM_W'(dt4[0]) + SUM_W'(dt4[1]) + SUM_W'(dt4[2]);
      tr5  <= SUM_W'(tt4[0]) + SUM_W'(tt4[1]) + SUM_W'(tt4[2]);
      for (int j = 0; j < 3; j++) begin
        cr5[j] <= cr4[j];
      end
    end
  end

  // stage 6: magnitudes and quotient signs
  logic             v6;
  row_t             r6;
  logic [MAG_W-1:0] ad6;
  logic [MAG_W-1:0] at6;
  logic [COF_W-1:0] ac6 [3];
  logic [LANES-1:0] neg6;
  logic             dz6;
  logic [SUM_W-1:0] det_abs;
  logic [SUM_W-1:0] tr_abs;

  assign det_abs = det5[SUM_W-1] ? SUM_W'(0) - det5 : det5;
  assign tr_abs  = tr5[SUM_W-1]  ? SUM_W'(0) - tr5  : tr5;

  always_ff @(posedge clk) begin
    if (adv) begin
      r6  <= r5;
      ad6 <= det_abs[MAG_W-1:0];
      at6 <= tr_abs[MAG_W-1:0];
      dz6 <= (det5 == '0);
      for (int j = 0; j < 3; j++) begin
        ac6[j]  <= cr5[j][COF_W-1] ? COF_W'(0) - cr5[j] : cr5[j];
        neg6[j] <= cr5[j][COF_W-1] ^ det5[SUM_W-1];
      end
      // translation is negated: before the determinant's sign is applied, its sign is set when the sum is positive
      neg6[LANES-1] <= (!tr5[SUM_W-1] && (tr5 != '0)) ^ det5[SUM_W-1];
    end
  end

  // stage 7: dividends 2|n| + |d| and divisor 2|d|
  logic                        v7;
  row_t                        r7;
  logic                        dz7;
  logic [LANES-1:0][NUM_W-1:0] num7;
  logic [NUM_W-1:0]            den7;
  logic [LANES-1:0]            neg7;

  always_ff @(posedge clk) begin
    if (adv) begin
      r7   <= r6;
      dz7  <= dz6;
      neg7 <= neg6;
      den7 <= NUM_W'(ad6) << 1;
      for (int j = 0; j < 3; j++) begin
        num7[j] <= (NUM_W'(ac6[j]) << (2 * FRAC_BITS + 1)) + NUM_W'(ad6);
      end
      num7[LANES-1] <= (NUM_W'(at6) << (FRAC_BITS + 1)) + NUM_W'(ad6);
    end
  end

  // valid bits of the arithmetic stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  // divider and its side line
  logic [LANES-1:0][DATA_W-1:0] div_res;
  logic [LANES-1:0]             div_sat;

  ati_div_pipe #(
    .W (NUM_W)
  ) u_div (
    .clk (clk),
    .en  (adv),
    .num (num7),
    .den (den7),
    .neg (neg7),
    .res (div_res),
    .sat (div_sat)
  );

  logic sd_v  [DIV_LAT];
  row_t sd_r  [DIV_LAT];
  logic sd_dz [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        sd_v[k] <= 1'b0;
      end
    end else if (adv) begin
      sd_v[0] <= v7;
      for (int k = 1; k < DIV_LAT; k++) begin
        sd_v[k] <= sd_v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0]  <= r7;
      sd_dz[0] <= dz7;
      for (int k = 1; k < DIV_LAT; k++) begin
        sd_r[k]  <= sd_r[k-1];
        sd_dz[k] <= sd_dz[k-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= sd_v[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.row_index <= sd_r[DIV_LAT-1];
      out_ch.last_row  <= (sd_r[DIV_LAT-1] == ROW_LAST);
      out_ch.singular  <= sd_dz[DIV_LAT-1];
      if (sd_dz[DIV_LAT-1]) begin
        out_ch.col0      <= '0;
        out_ch.col1      <= '0;
        out_ch.col2      <= '0;
        out_ch.col3      <= '0;
        out_ch.saturated <= 1'b0;
      end else begin
        out_ch.col0      <= div_res[0];
        out_ch.col1      <= div_res[1];
        out_ch.col2      <= div_res[2];
        out_ch.col3      <= div_res[3];
        out_ch.saturated <= |div_sat;
      end
    end
  end

  assign out_ch.valid = out_v;

  // expected row of the next output word
  row_t exp_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_row <= ROW0;
    end else if (out_ch.valid && out_ch.ready) begin
      exp_row <= (exp_row == ROW_LAST) ? ROW0 : exp_row + ROW_W'(1);
    end
  end

  // rows leave in order 0, 1, 2 for every transform
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.row_index == exp_row))
    else $error("row order broken");

  // last flag marks the final row only
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.last_row == (out_ch.row_index == ROW_LAST)))
    else $error("last_row mismatch");

  // a singular transform gives zero rows with no clamp
  a_singular: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.singular) |->
      (out_ch.col0 == '0 && out_ch.col1 == '0 && out_ch.col2 == '0 &&
       out_ch.col3 == '0 && !out_ch.saturated))
    else $error("singular row not cleared");

  // a new transform is taken while one is held only as the held one issues row 2
  a_issue: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && hold_v) |-> (cnt == ROW_LAST && adv))
    else $error("transform overwritten before all rows issued");

endmodule

// File: tb/ati_checker.sv
`timescale 1ns / 1ps
// ati_checker: watches both channels of the affine inverse core, predicts rows, compares
// depends on ati_pkg and ati_if

module ati_checker
  import ati_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  ati_in_if    in_ch,
  ati_out_if   out_ch,
  output int   errors,
  output int   pending
);

  typedef logic signed [129:0] wide_t;
  typedef logic        [129:0] mag_t;

  typedef struct {
    row_t  row;
    word_t col [4];
    logic  singular;
    logic  saturated;
    logic  last;
  } row_word_t;

  row_word_t rows_due [$];

  assign pending = rows_due.size();

  // quotient rounded half away from zero, clamped to 32 bits
  function automatic word_t div_round(input wide_t n, input wide_t d, inout logic sat);
    logic neg;
    mag_t an, ad, q, lim;
    neg = (n < 0) ^ (d < 0);
    an  = (n < 0) ? mag_t'(-n) : mag_t'(n);
    ad  = (d < 0) ? mag_t'(-d) : mag_t'(d);
    q   = ((an << 1) + ad) / (ad << 1);
    lim = neg ? mag_t'(64'h8000_0000) : mag_t'(64'h7FFF_FFFF);
    if (q > lim) begin
      sat = 1'b1;
      return word_t'(lim[31:0]);
    end
    return neg ? word_t'(-q[31:0]) : word_t'(q[31:0]);
  endfunction

  // cofactors, determinant and the three rows of the inverse
  task automatic predict_rows(input word_t m [12]);
    wide_t a [3][4];
    wide_t c [3][3];
    wide_t det, t;
    row_word_t r;
    logic sat;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 4; j++) a[i][j] = wide_t'(m[i*4+j]);
    c[0][0] = a[1][1]*a[2][2] - a[1][2]*a[2][1];
    c[0][1] = a[0][2]*a[2][1] - a[0][1]*a[2][2];
    c[0][2] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
    c[1][0] = a[1][2]*a[2][0] - a[1][0]*a[2][2];
    c[1][1] = a[0][0]*a[2][2] - a[0][2]*a[2][0];
    c[1][2] = a[0][2]*a[1][0] - a[0][0]*a[1][2];
    c[2][0] = a[1][0]*a[2][1] - a[1][1]*a[2][0];
    c[2][1] = a[0][1]*a[2][0] - a[0][0]*a[2][1];
    c[2][2] = a[0][0]*a[1][1] - a[0][1]*a[1][0];
    det = a[0][0]*c[0][0] + a[0][1]*c[1][0] + a[0][2]*c[2][0];
    for (int i = 0; i < 3; i++) begin
      sat = 1'b0;
      r.row  = row_t'(i);
      r.last = (r.row == ROW_LAST);
      if (det == 0) begin
        for (int j = 0; j < 4; j++) r.col[j] = '0;
        r.singular = 1'b1;
      end else begin
        for (int j = 0; j < 3; j++)
          r.col[j] = div_round(c[i][j] <<< (2*FRAC_BITS), det, sat);
        t = c[i][0]*a[0][3] + c[i][1]*a[1][3] + c[i][2]*a[2][3];
        r.col[3] = div_round(-(t <<< FRAC_BITS), det, sat);
        r.singular = 1'b0;
      end
      r.saturated = sat;
      rows_due.push_back(r);
    end
  endtask

  // sample accepted words on both channels
  always @(posedge clk) begin
    word_t m [12];
    row_word_t e;
    if (rst) begin
      errors <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        m = '{in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m03,
              in_ch.m10, in_ch.m11, in_ch.m12, in_ch.m13,
              in_ch.m20, in_ch.m21, in_ch.m22, in_ch.m23};
        predict_rows(m);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (rows_due.size() == 0) begin
          $display("%0t: unexpected row word, actual row %0d", $time, out_ch.row_index);
          errors <= errors + 1;
        end else begin
          e = rows_due.pop_front();
          if (e.row !== out_ch.row_index || e.col[0] !== out_ch.col0 ||
              e.col[1] !== out_ch.col1 || e.col[2] !== out_ch.col2 ||
              e.col[3] !== out_ch.col3 || e.singular !== out_ch.singular ||
              e.saturated !== out_ch.saturated || e.last !== out_ch.last_row) begin
            $display("%0t: mismatch expected row %0d %h %h %h %h sing %b sat %b last %b",
                     $time, e.row, e.col[0], e.col[1], e.col[2], e.col[3],
                     e.singular, e.saturated, e.last);
            $display("%0t:          actual   row %0d %h %h %h %h sing %b sat %b last %b",
                     $time, out_ch.row_index, out_ch.col0, out_ch.col1, out_ch.col2,
                     out_ch.col3, out_ch.singular, out_ch.saturated, out_ch.last_row);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus, handshake pressure and verdict for affine_transform_inverse_core
// depends on ati_pkg, ati_if, ati_checker and the core

module tb_top;
  import ati_pkg::*;

  typedef word_t mat_t [12];

  localparam int IDLE_LIMIT = 3000;
  localparam word_t ONE = 32'sh0001_0000;
  localparam word_t MAXV = 32'sh7FFF_FFFF;
  localparam word_t MINV = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending;
  int   idle_cycles = 0;

  ati_in_if  in_ch ();
  ati_out_if out_ch ();

  affine_transform_inverse_core #(.FRAC_BITS(16)) i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  ati_checker #(.FRAC_BITS(16)) i_checker (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .errors(errors), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stall pattern: phases of full speed, light and heavy stalls
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(10, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: begin
        out_ch.ready <= 1'b1;
      end
      1: begin
        out_ch.ready <= ($urandom_range(0, 9) < 7);
      end
      default: begin
        out_ch.ready <= ($urandom_range(0, 19) == 0);
      end
    endcase
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic word_t rnd32();
    return word_t'($urandom);
  endfunction

  function automatic word_t near(input int span);
    return word_t'($signed($urandom_range(0, 2*span)) - span);
  endfunction

  // random transform of one of several shapes
  function automatic mat_t random_transform();
    mat_t m;
    int kind;
    kind = $urandom_range(0, 99);
    for (int k = 0; k < 12; k++) m[k] = rnd32();
    if (kind < 55) begin
      // well-conditioned: diagonal near one or two, modest off-diagonals
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          m[i*4+j] = (i == j) ? word_t'(ONE + near(1 << 15) + ((i & 1) ? 0 : ONE))
                              : near(1 << 16);
      if ($urandom_range(0, 3) == 0) m[0] = -m[0];
    end else if (kind < 70) begin
      // tiny entries: huge inverse, saturation
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) m[i*4+j] = near($urandom_range(0, 1) ? 8 : 300);
    end else if (kind < 82) begin
      // singular: repeated row or zero column
      if ($urandom_range(0, 1)) begin
        for (int j = 0; j < 3; j++) m[8+j] = m[j];
      end else begin
        for (int i = 0; i < 3; i++) m[i*4+1] = '0;
      end
    end
    return m;
  endfunction

  task automatic drive_word(input mat_t m);
    in_ch.valid <= 1'b1;
    in_ch.m00 <= m[0];  in_ch.m01 <= m[1];  in_ch.m02 <= m[2];  in_ch.m03 <= m[3];
    in_ch.m10 <= m[4];  in_ch.m11 <= m[5];  in_ch.m12 <= m[6];  in_ch.m13 <= m[7];
    in_ch.m20 <= m[8];  in_ch.m21 <= m[9];  in_ch.m22 <= m[10]; in_ch.m23 <= m[11];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  mat_t directed [$];
  mat_t m;
  int   burst_left;

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m03} = '0;
    {in_ch.m10, in_ch.m11, in_ch.m12, in_ch.m13} = '0;
    {in_ch.m20, in_ch.m21, in_ch.m22, in_ch.m23} = '0;

    // identity, scaled, all zero, extremes, tiny and negated transforms
    directed.push_back('{ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0});
    directed.push_back('{ONE, 0, 0, MAXV, 0, ONE, 0, MINV, 0, 0, ONE, ONE});
    directed.push_back('{2*ONE, 0, 0, ONE, 0, 4*ONE, 0, -ONE, 0, 0, -ONE, 3});
    directed.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV,
                         MAXV, MAXV, MAXV, MAXV});
    directed.push_back('{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV,
                         MINV, MINV, MINV, MINV});
    directed.push_back('{MAXV, 0, 0, MINV, 0, MAXV, 0, MAXV, 0, 0, MAXV, MINV});
    directed.push_back('{MINV, 0, 0, MAXV, 0, MINV, 0, MINV, 0, 0, MINV, MAXV});
    directed.push_back('{MINV, MAXV, 0, -1, 0, MINV, MAXV, 1, MAXV, 0, MINV, -1});
    directed.push_back('{1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0});
    directed.push_back('{-1, 0, 0, MAXV, 0, -1, 0, MINV, 0, 0, 1, 1});
    directed.push_back('{3, 0, 0, 0, 0, 3, 0, 0, 0, 0, 3, 0});
    directed.push_back('{2, 1, 0, 5, 1, 2, 1, -5, 0, 1, 2, 7});
    directed.push_back('{ONE, 2*ONE, 3*ONE, 1, 4*ONE, 5*ONE, 6*ONE, 2,
                         7*ONE, 8*ONE, 9*ONE, 3});
    directed.push_back('{0, ONE, 0, ONE, ONE, 0, 0, -ONE, 0, 0, ONE, 0});
    directed.push_back('{-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                         -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1});

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    burst_left = $urandom_range(1, 8);
    for (int n = 0; n < directed.size() + 260; n++) begin
      m = (n < directed.size()) ? directed[n] : random_transform();
      drive_word(m);
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(0, 10);
      end else begin
        burst_left--;
      end
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
